// ----- rtl/adaptive_grid_bilinear_lookup_top_assert.svh -----
// Assertion macros for the quadtree bilinear lookup block.
`ifndef ADAPTIVE_GRID_BILINEAR_LOOKUP_TOP_ASSERT_SVH
`define ADAPTIVE_GRID_BILINEAR_LOOKUP_TOP_ASSERT_SVH

// Checks a consequence in the same cycle as its condition.
`define AGBL_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Checks a consequence in the cycle after its condition.
`define AGBL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/agbl_pkg.sv -----
// Shared types and constants for the quadtree bilinear lookup block.
`timescale 1ns / 1ps
package agbl_pkg;

  localparam int DATA_W   = 240;
  localparam int OUT_W    = 40;
  localparam int BOX_W    = 31;
  localparam int MAG_W    = 32;

  localparam logic [1:0] OP_QUERY   = 2'd0;
  localparam logic [1:0] OP_WR_CELL = 2'd1;
  localparam logic [1:0] OP_WR_BASE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_DEEP    = 2'd2;

  localparam logic             REG_BOX   = 1'b0;
  localparam logic [BOX_W-1:0] BOX_RESET = 31'd65536;

  localparam logic [3:0] DIV_LAST   = 4'd15;
  localparam logic [3:0] BLEND_LAST = 4'd8;

  typedef struct packed {
    logic wr_cell;
    logic wr_base;
    logic load;
    logic div_step;
    logic red_step;
    logic fetch;
    logic descend;
    logic blend_start;
    logic blend_step;
    logic set_deep;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic div_done;
    logic red_done;
    logic refined;
    logic last_layer;
    logic blend_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/agbl_ctrl.sv -----
// Sequencer for table writes and for query, descent and blend steps.
`timescale 1ns / 1ps
module agbl_ctrl import agbl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic [1:0] operation,
  input  sts_t       sts,
  output logic       s_tready,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {IDLE, DIVIDE, REDUCE, FETCH, LOOK, BLEND, DONE} state_t;

  state_t state;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: begin
        if (s_tvalid) begin
          case (operation)
            OP_QUERY:   cmd.load    = 1'b1;
            OP_WR_CELL: cmd.wr_cell = 1'b1;
            OP_WR_BASE: cmd.wr_base = 1'b1;
            default: ;
          endcase
        end
      end
      DIVIDE: cmd.div_step = 1'b1;
      REDUCE: cmd.red_step = 1'b1;
      FETCH:  cmd.fetch    = 1'b1;
      LOOK: begin
        if (!sts.refined) begin
          cmd.blend_start = 1'b1;
        end else if (sts.last_layer) begin
          cmd.set_deep = 1'b1;
        end else begin
          cmd.descend = 1'b1;
        end
      end
      BLEND: cmd.blend_step = 1'b1;
      DONE:  cmd.emit       = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= sts.outside ? DONE : DIVIDE;
          end
        end
        DIVIDE: if (sts.div_done) state <= REDUCE;
        REDUCE: if (sts.red_done) state <= FETCH;
        FETCH:  state <= LOOK;
        LOOK: begin
          if (!sts.refined) begin
            state <= BLEND;
          end else if (sts.last_layer) begin
            state <= DONE;
          end else begin
            state <= REDUCE;
          end
        end
        BLEND: if (sts.blend_done) state <= DONE;
        DONE:  if (sts.out_free) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/agbl_dp.sv -----
// Datapath: tables, normalizing divider, index reduction, blend and result register.
`timescale 1ns / 1ps
module agbl_dp import agbl_pkg::*; #(
  parameter int CELL_COUNT = 65536,
  parameter int MAX_LAYERS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [DATA_W-1:0] s_tdata,
  input  logic [BOX_W-1:0]  half_width,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [OUT_W-1:0]  m_tdata
);

  localparam int IDXW = $clog2(CELL_COUNT);
  localparam int LAYW = $clog2(MAX_LAYERS + 1);
  localparam int BIW  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int RW   = 40;
  localparam bit IS_POW2 = ((CELL_COUNT & (CELL_COUNT - 1)) == 0);
  localparam logic [2:0] RC_INIT = IS_POW2 ? 3'd0 : 3'd4;

  // Input fields.
  logic [15:0]  f_index;
  logic         f_densed;
  logic [13:0]  f_group;
  logic [127:0] f_corners;
  logic [15:0]  f_base;
  logic [31:0]  f_x;
  logic [31:0]  f_y;

  assign f_index   = s_tdata[15:0];
  assign f_densed  = s_tdata[16];
  assign f_group   = s_tdata[30:17];
  assign f_corners = s_tdata[158:31];
  assign f_base    = s_tdata[174:159];
  assign f_x       = s_tdata[206:175];
  assign f_y       = s_tdata[238:207];

  // Tables.
  logic [14:0]  cell_meta   [CELL_COUNT];
  logic [127:0] cell_corner [CELL_COUNT];
  logic [15:0]  base_tbl    [MAX_LAYERS];
  logic [14:0]  meta_q;
  logic [127:0] corner_q;

  // Working registers.
  logic [30:0]     rem_x, rem_y;
  logic [31:0]     quo_x, quo_y;
  logic            nbit_x, nbit_y;
  logic [3:0]      dc;
  logic [16:0]     red;
  logic [2:0]      rc;
  logic [LAYW-1:0] layer;
  logic [3:0]      bstep;
  logic [32:0]     wprod [4];
  logic [64:0]     prod;
  logic [63:0]     acc;
  logic [1:0]      res_status;
  logic [3:0]      res_depth;

  // Bounds test and offset numerators.
  logic signed [32:0] sx, sy, sb, ax, ay;
  logic               outside;

  assign sb = $signed({2'b00, half_width});
  assign sx = $signed({f_x[31], f_x});
  assign sy = $signed({f_y[31], f_y});
  assign ax = sx + sb;
  assign ay = sy + sb;
  assign outside = (half_width == '0) || (sx <= -sb) || (sx >= sb) ||
                   (sy <= -sb) || (sy >= sb);

  // Two restoring division steps; returns {quotient bits, remainder}.
  function automatic logic [32:0] div_step2(input logic [30:0] r, input logic b,
                                            input logic [30:0] d);
    logic [31:0] t;
    logic [30:0] rr;
    logic [1:0]  q;
    rr = r;
    q  = '0;
    t  = {rr, b};
    if (t >= {1'b0, d}) begin
      rr   = 31'(t - {1'b0, d});
      q[1] = 1'b1;
    end else begin
      rr = t[30:0];
    end
    t = {rr, 1'b0};
    if (t >= {1'b0, d}) begin
      rr   = 31'(t - {1'b0, d});
      q[0] = 1'b1;
    end else begin
      rr = t[30:0];
    end
    return {q, rr};
  endfunction

  logic [32:0] dsx, dsy;
  assign dsx = div_step2(rem_x, nbit_x, half_width);
  assign dsy = div_step2(rem_y, nbit_y, half_width);

  // Index reduction: four compare-and-subtract steps per cycle, largest multiple first.
  logic [RW-1:0] red_tmp;
  logic [RW-1:0] red_sub;
  logic [4:0]    red_k;
  logic [RW-1:0] red_wide;

  always_comb begin
    red_tmp = RW'(red);
    red_sub = '0;
    red_k   = '0;
    for (int j = 3; j >= 0; j--) begin
      red_k   = {rc, 2'b00} + 5'(j);
      red_sub = RW'(CELL_COUNT) << red_k;
      if (red_tmp >= red_sub) begin
        red_tmp = red_tmp - red_sub;
      end
    end
  end

  assign red_wide = RW'(red);

  logic [IDXW-1:0] cell_addr;
  assign cell_addr = red_wide[IDXW-1:0];

  // Next child index.
  logic [31:0]    lay_inc;
  logic [BIW-1:0] base_idx;
  logic [16:0]    child_idx;

  assign lay_inc   = 32'(layer) + 32'd1;
  assign base_idx  = lay_inc[BIW-1:0];
  assign child_idx = 17'(base_tbl[base_idx]) + {1'b0, meta_q[13:0], 2'b00} +
                     {15'd0, quo_y[31], quo_x[31]};

  // Write addressing.
  logic [31:0]     widx;
  logic [IDXW-1:0] waddr;
  logic [BIW-1:0]  wbase;
  assign widx  = 32'(f_index);
  assign waddr = widx[IDXW-1:0];
  assign wbase = widx[BIW-1:0];

  // Blend multiplier operands.
  logic [15:0] wx, wy;
  logic [16:0] ix, iy;
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [3:0]  bm1;

  assign wx  = quo_x[31:16];
  assign wy  = quo_y[31:16];
  assign ix  = 17'h10000 - {1'b0, wx};
  assign iy  = 17'h10000 - {1'b0, wy};
  assign bm1 = bstep - 4'd1;

  always_comb begin
    case (bstep)
      4'd0: begin mul_a = 33'(ix); mul_b = 32'(iy); end
      4'd1: begin mul_a = 33'(wx); mul_b = 32'(iy); end
      4'd2: begin mul_a = 33'(ix); mul_b = 32'(wy); end
      4'd3: begin mul_a = 33'(wx); mul_b = 32'(wy); end
      default: begin
        mul_a = wprod[bstep[1:0]];
        mul_b = corner_q[32 * bstep[1:0] +: 32];
      end
    endcase
  end

  logic [63:0]      rnd;
  logic [MAG_W-1:0] mag;
  logic [31:0]      layer_ext;
  assign rnd       = acc + 64'h8000_0000;
  assign mag       = (res_status == ST_OK) ? rnd[63:32] : '0;
  assign layer_ext = 32'(layer);

  assign sts.outside    = outside;
  assign sts.div_done   = (dc == DIV_LAST);
  assign sts.red_done   = (rc == 3'd0);
  assign sts.refined    = meta_q[14];
  assign sts.last_layer = (lay_inc >= 32'(MAX_LAYERS));
  assign sts.blend_done = (bstep == BLEND_LAST);
  assign sts.out_free   = !m_tvalid || m_tready;

  // Table writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.wr_cell && (widx < 32'(CELL_COUNT))) begin
      cell_meta[waddr]   <= {f_densed, f_group};
      cell_corner[waddr] <= f_corners;
    end
    if (cmd.fetch) begin
      meta_q   <= cell_meta[cell_addr];
      corner_q <= cell_corner[cell_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_base && (widx < 32'(MAX_LAYERS))) begin
      base_tbl[wbase] <= f_base;
    end
  end

  // Query working state.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_x      <= ax[31:1];
      rem_y      <= ay[31:1];
      nbit_x     <= ax[0];
      nbit_y     <= ay[0];
      quo_x      <= '0;
      quo_y      <= '0;
      dc         <= '0;
      red        <= 17'(base_tbl[0]);
      rc         <= RC_INIT;
      layer      <= '0;
      res_status <= outside ? ST_OUTSIDE : ST_OK;
      res_depth  <= '0;
      acc        <= '0;
    end
    if (cmd.div_step) begin
      rem_x  <= dsx[30:0];
      rem_y  <= dsy[30:0];
      quo_x  <= {quo_x[29:0], dsx[32:31]};
      quo_y  <= {quo_y[29:0], dsy[32:31]};
      nbit_x <= 1'b0;
      nbit_y <= 1'b0;
      dc     <= dc + 4'd1;
    end
    if (cmd.red_step) begin
      red <= red_tmp[16:0];
      if (rc != 3'd0) begin
        rc <= rc - 3'd1;
      end
    end
    if (cmd.descend) begin
      red   <= child_idx;
      rc    <= RC_INIT;
      layer <= layer + LAYW'(1);
      quo_x <= {quo_x[30:0], 1'b0};
      quo_y <= {quo_y[30:0], 1'b0};
    end
    if (cmd.set_deep) begin
      res_status <= ST_DEEP;
    end
    if (cmd.blend_start) begin
      bstep     <= '0;
      acc       <= '0;
      res_depth <= layer_ext[3:0];
    end
    if (cmd.blend_step) begin
      prod  <= mul_a * mul_b;
      bstep <= bstep + 4'd1;
      if ((bstep >= 4'd1) && (bstep <= 4'd4)) begin
        wprod[bm1[1:0]] <= prod[32:0];
      end
      if (bstep >= 4'd5) begin
        acc <= acc + prod[63:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {2'b00, res_depth, res_status, mag};
    end
  end

endmodule

// ----- rtl/adaptive_grid_bilinear_lookup_top.sv -----
// Top level of the quadtree bilinear lookup block: config register and wiring.
//
//  channel  direction  beat contents
//  s_*      in         tuser: operation; tdata: index, densed, child_group, corners
//                      one to four, layer_base, point_x, point_y
//  m_*      out        tdata: magnification, status, depth_reached
//  p*       in/out     half-width register at byte address 0
//
// A table write beat is taken without leaving IDLE; a point outside the box goes
// straight to DONE. An inside query passes the two-bit divider, then a reduce, fetch
// and look step per layer visited, then the 9-step blend; a CELL_COUNT that is not
// a power of two makes each layer's reduction start from a higher multiple of it.
// Reset is synchronous; the cell tables hold no reset value and need no clearing.
// A stalled result holds in the output register; the next beat is taken meanwhile.
`timescale 1ns / 1ps
`include "adaptive_grid_bilinear_lookup_top_assert.svh"
module adaptive_grid_bilinear_lookup_top import agbl_pkg::*; #(
  parameter int CELL_COUNT = 65536,
  parameter int MAX_LAYERS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // index[15:0], densed[16], child_group[30:17], corner_one[62:31],
  // corner_two[94:63], corner_three[126:95], corner_four[158:127],
  // layer_base[174:159], point_x[206:175], point_y[238:207], zero pad[239]
  input  logic [DATA_W-1:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // magnification[31:0], status[33:32], depth_reached[37:34], zero pad[39:38]
  output logic [OUT_W-1:0]  m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [BOX_W-1:0] half_width;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BOX) ? {1'b0, half_width} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= BOX_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BOX)) begin
      half_width <= pwdata[BOX_W-1:0];
    end
  end

  agbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .operation (s_tuser),
    .sts       (sts),
    .s_tready  (s_tready),
    .cmd       (cmd)
  );

  agbl_dp #(
    .CELL_COUNT (CELL_COUNT),
    .MAX_LAYERS (MAX_LAYERS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .half_width (half_width),
    .cmd        (cmd),
    .sts        (sts),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata)
  );

  `AGBL_ASSERT_NOW(a_err_mag_zero, m_tvalid && (m_tdata[33:32] != ST_OK), m_tdata[31:0] == '0, "magnification not zero on an error result")
  `AGBL_ASSERT_NOW(a_err_depth_zero, m_tvalid && (m_tdata[33:32] != ST_OK), m_tdata[37:34] == '0, "depth not zero on an error result")
  `AGBL_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && (s_tuser == OP_QUERY), !s_tready, "sequencer stayed idle after a query beat")
  `AGBL_ASSERT_NOW(a_result_source, $rose(m_tvalid), $past(cmd.emit), "result beat raised without an emit command")

endmodule
